// File: hw/rtl/bankers_safety_and_request_macros.svh
// Assertion macros shared by the banker's safety and request engine.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef BANKERS_SAFETY_AND_REQUEST_MACROS_SVH
`define BANKERS_SAFETY_AND_REQUEST_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, held off during reset
`define BSR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bankers_safety_and_request: check failed");
// Clocked check with its own message
`define BSR_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`else
`define BSR_ASSERT(lbl, prop)
`define BSR_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/bsr_pkg.sv
// Package for the banker's safety and request engine: field widths,
// command, status, configuration and table operation codes.
// Depends on nothing.
package bsr_pkg;

    localparam int CMD_W        = 3;
    localparam int PIDX_PORT_W  = 3;
    localparam int STATUS_W     = 3;
    localparam int PC_W         = 3;
    localparam int RC_W         = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int SHOWN_ORDERS = 5;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [2:0]          t_tab_op;

    // Commands
    localparam t_cmd CMD_LOAD_AVAIL = 3'd0;
    localparam t_cmd CMD_LOAD_MAX   = 3'd1;
    localparam t_cmd CMD_LOAD_ALLOC = 3'd2;
    localparam t_cmd CMD_CHECK      = 3'd3;
    localparam t_cmd CMD_REQUEST    = 3'd4;

    // Result status
    localparam t_status ST_LOADED      = 3'd0;
    localparam t_status ST_SAFE        = 3'd1;
    localparam t_status ST_UNSAFE      = 3'd2;
    localparam t_status ST_GRANTED     = 3'd3;
    localparam t_status ST_EXCEEDS     = 3'd4;
    localparam t_status ST_MUST_WAIT   = 3'd5;
    localparam t_status ST_DENIED      = 3'd6;
    localparam t_status ST_BAD_PROCESS = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 2'd1;

    // Table update operations
    localparam t_tab_op TOP_NONE       = 3'd0;
    localparam t_tab_op TOP_LOAD_AVAIL = 3'd1;
    localparam t_tab_op TOP_LOAD_MAX   = 3'd2;
    localparam t_tab_op TOP_LOAD_ALLOC = 3'd3;
    localparam t_tab_op TOP_GRANT      = 3'd4;
    localparam t_tab_op TOP_UNDO       = 3'd5;

    typedef struct packed {
        t_tab_op         op;
        logic [RC_W-1:0] res_count;
    } t_tab_ctl;

endpackage

// File: hw/rtl/bankers_safety_and_request.sv
// Banker's algorithm engine: command sequencer, safety scan and result register.
// Depends on bsr_pkg, bsr_tables, bsr_fit_unit and the assertion macro header.
//
// One command per input transaction, one result per command. Loads, rejected
// requests and bad process indexes pass from acceptance through the decode and
// finish states into the output register. A safety check, and a request
// that passes its need and availability checks, run a scan that visits one
// process per cycle, up to process_count passes over the processes, through the
// shared row unit, before the finish state. The input is taken only while the
// sequencer is idle; a finished result may wait in the output register while
// the next command is taken. Configuration writes are always accepted and are
// meant to be made only while the engine is idle.
`include "bankers_safety_and_request_macros.svh"

module bankers_safety_and_request import bsr_pkg::*; #(
    parameter int PROCESSES   = 5,
    parameter int RESOURCES   = 3,
    parameter int AMOUNT_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // command input
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [PIDX_PORT_W-1:0] i_process_index,
    input  logic [AMOUNT_BITS-1:0] i_amount_0,
    input  logic [AMOUNT_BITS-1:0] i_amount_1,
    input  logic [AMOUNT_BITS-1:0] i_amount_2,
    // result output
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [2:0]             o_finished_count,
    output logic [2:0]             o_order_0,
    output logic [2:0]             o_order_1,
    output logic [2:0]             o_order_2,
    output logic [2:0]             o_order_3,
    output logic [2:0]             o_order_4
);

    localparam int PIDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int CNT_W  = $clog2(PROCESSES + 1);
    localparam int WORK_W = AMOUNT_BITS + CNT_W;
    localparam int CMP_W  = 4;

    localparam logic [PC_W-1:0] PC_RESET = PC_W'((PROCESSES < 5) ? PROCESSES : 5);
    localparam logic [RC_W-1:0] RC_RESET = RC_W'((RESOURCES < 3) ? RESOURCES : 3);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_INIT   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]                            r_state, n_state;
    logic [PC_W-1:0]                       r_proc_count;
    logic [RC_W-1:0]                       r_res_count;

    // latched command
    t_cmd                                  r_cmd;
    logic [PIDX_PORT_W-1:0]                r_pidx;
    logic [RESOURCES-1:0][AMOUNT_BITS-1:0] r_amt;

    // scan state
    logic [RESOURCES-1:0][WORK_W-1:0]      r_work, n_work;
    logic [PROCESSES-1:0]                  r_done, n_done;
    logic [PIDX_W-1:0]                     r_scan_p, n_scan_p;
    logic [PC_W-1:0]                       r_pass, n_pass;
    logic                                  r_any, n_any;
    logic [CNT_W-1:0]                      r_admitted, n_admitted;
    logic [PROCESSES-1:0][PIDX_W-1:0]      r_order, n_order;
    logic                                  r_is_req, n_is_req;

    // pending result
    t_status                               r_st, n_st;
    logic                                  r_show, n_show;
    logic [CNT_W-1:0]                      r_fin, n_fin;

    // output register
    logic                                  r_out_valid;
    t_status                               r_o_status;
    logic [2:0]                            r_o_fin;
    logic [SHOWN_ORDERS-1:0][2:0]          r_o_order;

    logic                                  in_fire;
    logic                                  out_load;
    logic                                  bad;
    logic                                  admit;
    logic                                  last_p;
    logic                                  any_now;
    logic                                  all_in;
    logic [CNT_W-1:0]                      adm_next;
    logic [PIDX_W-1:0]                     pidx_row;
    logic [PIDX_W-1:0]                     rd_row;
    logic [2:0][AMOUNT_BITS-1:0]           amt_all;
    logic [PC_W-1:0]                       pc_wr;
    logic [RC_W-1:0]                       rc_wr;
    logic [SHOWN_ORDERS-1:0][2:0]          shown_order;
    t_tab_ctl                              tab_ctl;

    logic [RESOURCES-1:0][AMOUNT_BITS-1:0] avail;
    logic [RESOURCES-1:0][AMOUNT_BITS-1:0] max_row;
    logic [RESOURCES-1:0][AMOUNT_BITS-1:0] alloc_row;
    logic [RESOURCES-1:0][WORK_W-1:0]      work_sum;
    logic                                  fits;
    logic                                  over;
    logic                                  wait_req;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign amt_all     = {i_amount_2, i_amount_1, i_amount_0};
    assign pidx_row    = r_pidx[PIDX_W-1:0];
    assign rd_row      = (r_state == S_SCAN) ? r_scan_p : pidx_row;

    // Configuration values clamped into range
    always_comb begin
        pc_wr = i_cfg_data[PC_W-1:0];
        if (pc_wr == '0) begin
            pc_wr = PC_W'(1);
        end else if ({1'b0, pc_wr} > (PC_W + 1)'(PROCESSES)) begin
            pc_wr = PC_W'(PROCESSES);
        end
        rc_wr = i_cfg_data[RC_W-1:0];
        if (rc_wr == '0) begin
            rc_wr = RC_W'(1);
        end else if ({1'b0, rc_wr} > (RC_W + 1)'(RESOURCES)) begin
            rc_wr = RC_W'(RESOURCES);
        end
    end

    bsr_tables #(
        .PROCESSES   (PROCESSES),
        .RESOURCES   (RESOURCES),
        .AMOUNT_BITS (AMOUNT_BITS),
        .PIDX_W      (PIDX_W)
    ) u_tables (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tab_ctl),
        .i_wr_row    (pidx_row),
        .i_amt       (r_amt),
        .i_rd_row    (rd_row),
        .o_avail     (avail),
        .o_max_row   (max_row),
        .o_alloc_row (alloc_row)
    );

    bsr_fit_unit #(
        .RESOURCES   (RESOURCES),
        .AMOUNT_BITS (AMOUNT_BITS),
        .WORK_W      (WORK_W)
    ) u_fit (
        .i_res_count (r_res_count),
        .i_max_row   (max_row),
        .i_alloc_row (alloc_row),
        .i_avail     (avail),
        .i_amt       (r_amt),
        .i_work      (r_work),
        .o_fits      (fits),
        .o_over      (over),
        .o_wait      (wait_req),
        .o_work_sum  (work_sum)
    );

    // Scan step terms
    assign bad = ((r_cmd == CMD_LOAD_MAX) || (r_cmd == CMD_LOAD_ALLOC) ||
                  (r_cmd == CMD_REQUEST)) && (r_pidx >= r_proc_count);
    assign admit    = !r_done[r_scan_p] && fits;
    assign adm_next = r_admitted + CNT_W'(admit);
    assign last_p   = (PC_W'(r_scan_p) == (r_proc_count - PC_W'(1)));
    assign any_now  = r_any || admit;
    assign all_in   = (CMP_W'(adm_next) == CMP_W'(r_proc_count));
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_work        = r_work;
        n_done        = r_done;
        n_scan_p      = r_scan_p;
        n_pass        = r_pass;
        n_any         = r_any;
        n_admitted    = r_admitted;
        n_order       = r_order;
        n_is_req      = r_is_req;
        n_st          = r_st;
        n_show        = r_show;
        n_fin         = r_fin;
        tab_ctl.op        = TOP_NONE;
        tab_ctl.res_count = r_res_count;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_show  = 1'b0;
                n_fin   = '0;
                n_state = S_FINISH;
                n_st    = ST_LOADED;
                if (bad) begin
                    n_st = ST_BAD_PROCESS;
                end else begin
                    unique case (r_cmd)
                        CMD_LOAD_AVAIL: tab_ctl.op = TOP_LOAD_AVAIL;
                        CMD_LOAD_MAX:   tab_ctl.op = TOP_LOAD_MAX;
                        CMD_LOAD_ALLOC: tab_ctl.op = TOP_LOAD_ALLOC;
                        CMD_CHECK: begin
                            n_is_req = 1'b0;
                            n_state  = S_INIT;
                        end
                        CMD_REQUEST: begin
                            if (over) begin
                                n_st = ST_EXCEEDS;
                            end else if (wait_req) begin
                                n_st = ST_MUST_WAIT;
                            end else begin
                                tab_ctl.op = TOP_GRANT;
                                n_is_req   = 1'b1;
                                n_state    = S_INIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INIT: begin
                for (int r = 0; r < RESOURCES; r++) begin
                    n_work[r] = WORK_W'(avail[r]);
                end
                n_done     = '0;
                n_scan_p   = '0;
                n_pass     = '0;
                n_any      = 1'b0;
                n_admitted = '0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (admit) begin
                    n_work                                 = work_sum;
                    n_done[r_scan_p]                       = 1'b1;
                    n_order[r_admitted[PIDX_W-1:0]]        = r_scan_p;
                    n_admitted                             = adm_next;
                end
                if (all_in || (last_p && (!any_now || ((r_pass + PC_W'(1)) == r_proc_count))))
                begin
                    n_fin   = adm_next;
                    n_show  = 1'b1;
                    n_state = S_FINISH;
                    if (r_is_req) begin
                        n_st = all_in ? ST_GRANTED : ST_DENIED;
                        if (!all_in) begin
                            tab_ctl.op = TOP_UNDO;
                        end
                    end else begin
                        n_st = all_in ? ST_SAFE : ST_UNSAFE;
                    end
                end else if (last_p) begin
                    n_scan_p = '0;
                    n_pass   = r_pass + PC_W'(1);
                    n_any    = 1'b0;
                end else begin
                    n_scan_p = r_scan_p + PIDX_W'(1);
                    n_any    = any_now;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Safe order entries shown in the result
    genvar gi;
    generate
        for (gi = 0; gi < SHOWN_ORDERS; gi++) begin : g_shown
            if (gi < PROCESSES) begin : g_real
                assign shown_order[gi] = (r_show && (CMP_W'(gi) < CMP_W'(r_fin))) ?
                                         3'(r_order[gi]) : 3'd0;
            end else begin : g_none
                assign shown_order[gi] = 3'd0;
            end
        end
    endgenerate

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_proc_count <= PC_RESET;
            r_res_count  <= RC_RESET;
            r_out_valid  <= 1'b0;
            r_done       <= '0;
            r_admitted   <= '0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_admitted <= n_admitted;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PROCESS_COUNT) begin
                    r_proc_count <= pc_wr;
                end else if (i_cfg_index == CFG_RESOURCE_COUNT) begin
                    r_res_count <= rc_wr;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= i_command;
            r_pidx <= i_process_index;
            for (int r = 0; r < RESOURCES; r++) begin
                r_amt[r] <= amt_all[r];
            end
        end
        r_work   <= n_work;
        r_scan_p <= n_scan_p;
        r_pass   <= n_pass;
        r_any    <= n_any;
        r_order  <= n_order;
        r_is_req <= n_is_req;
        r_st     <= n_st;
        r_show   <= n_show;
        r_fin    <= n_fin;
        if (out_load) begin
            r_o_status <= r_st;
            r_o_fin    <= r_show ? 3'(r_fin) : 3'd0;
            r_o_order  <= shown_order;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_finished_count = r_o_fin;
    assign o_order_0        = r_o_order[0];
    assign o_order_1        = r_o_order[1];
    assign o_order_2        = r_o_order[2];
    assign o_order_3        = r_o_order[3];
    assign o_order_4        = r_o_order[4];

    // Checks
    `BSR_ASSERT(a_accept_decodes, in_fire |=> (r_state == S_DECODE))
    `BSR_ASSERT_MSG(a_done_matches_count, $countones(r_done) == int'(r_admitted), "done bits and admitted count disagree")
    `BSR_ASSERT_MSG(a_admitted_bounded, (r_state == S_SCAN) |-> (CMP_W'(r_admitted) < CMP_W'(r_proc_count)), "scan admitted too many")
    `BSR_ASSERT(a_finish_delivers, ((r_state == S_FINISH) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)))

endmodule

// File: hw/rtl/bsr_tables.sv
// Available vector, maximum and allocation tables with load, grant and undo.
// Depends on bsr_pkg.
module bsr_tables import bsr_pkg::*; #(
    parameter int PROCESSES   = 5,
    parameter int RESOURCES   = 3,
    parameter int AMOUNT_BITS = 8,
    parameter int PIDX_W      = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_tab_ctl                              i_ctl,
    input  logic [PIDX_W-1:0]                     i_wr_row,
    input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0] i_amt,
    input  logic [PIDX_W-1:0]                     i_rd_row,
    output logic [RESOURCES-1:0][AMOUNT_BITS-1:0] o_avail,
    output logic [RESOURCES-1:0][AMOUNT_BITS-1:0] o_max_row,
    output logic [RESOURCES-1:0][AMOUNT_BITS-1:0] o_alloc_row
);

    logic [RESOURCES-1:0][AMOUNT_BITS-1:0]                r_avail;
    logic [PROCESSES-1:0][RESOURCES-1:0][AMOUNT_BITS-1:0] r_max;
    logic [PROCESSES-1:0][RESOURCES-1:0][AMOUNT_BITS-1:0] r_alloc;

    // Table updates; grant and undo only touch the columns in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail <= '0;
            r_max   <= '0;
            r_alloc <= '0;
        end else begin
            unique case (i_ctl.op)
                TOP_LOAD_AVAIL: begin
                    r_avail <= i_amt;
                end
                TOP_LOAD_MAX: begin
                    r_max[i_wr_row] <= i_amt;
                end
                TOP_LOAD_ALLOC: begin
                    r_alloc[i_wr_row] <= i_amt;
                end
                TOP_GRANT: begin
                    for (int r = 0; r < RESOURCES; r++) begin
                        if (r < int'(i_ctl.res_count)) begin
                            r_avail[r]           <= r_avail[r] - i_amt[r];
                            r_alloc[i_wr_row][r] <= r_alloc[i_wr_row][r] + i_amt[r];
                        end
                    end
                end
                TOP_UNDO: begin
                    for (int r = 0; r < RESOURCES; r++) begin
                        if (r < int'(i_ctl.res_count)) begin
                            r_avail[r]           <= r_avail[r] + i_amt[r];
                            r_alloc[i_wr_row][r] <= r_alloc[i_wr_row][r] - i_amt[r];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Single read row, chosen by the sequencer
    assign o_avail     = r_avail;
    assign o_max_row   = r_max[i_rd_row];
    assign o_alloc_row = r_alloc[i_rd_row];

endmodule

// File: hw/rtl/bsr_fit_unit.sv
// Shared row unit: need = maximum - allocation per column, need-fits-work
// test, work accumulation and the request checks. Depends on bsr_pkg.
module bsr_fit_unit import bsr_pkg::*; #(
    parameter int RESOURCES   = 3,
    parameter int AMOUNT_BITS = 8,
    parameter int WORK_W      = 11
) (
    input  logic [RC_W-1:0]                       i_res_count,
    input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0] i_max_row,
    input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0] i_alloc_row,
    input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0] i_avail,
    input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0] i_amt,
    input  logic [RESOURCES-1:0][WORK_W-1:0]      i_work,
    output logic                                  o_fits,
    output logic                                  o_over,
    output logic                                  o_wait,
    output logic [RESOURCES-1:0][WORK_W-1:0]      o_work_sum
);

    logic [RESOURCES-1:0]                  neg;
    logic [RESOURCES-1:0]                  used;
    logic [RESOURCES-1:0][AMOUNT_BITS-1:0] need;

    // One lane per resource column; unused columns are masked out
    always_comb begin
        o_fits = 1'b1;
        o_over = 1'b0;
        o_wait = 1'b0;
        for (int r = 0; r < RESOURCES; r++) begin
            neg[r]        = i_alloc_row[r] > i_max_row[r];
            need[r]       = i_max_row[r] - i_alloc_row[r];
            used[r]       = r < int'(i_res_count);
            o_work_sum[r] = i_work[r] + WORK_W'(i_alloc_row[r]);
            if (used[r]) begin
                if (neg[r] || (WORK_W'(need[r]) > i_work[r])) begin
                    o_fits = 1'b0;
                end
                if (neg[r] || (i_amt[r] > need[r])) begin
                    o_over = 1'b1;
                end
                if (i_amt[r] > i_avail[r]) begin
                    o_wait = 1'b1;
                end
            end
        end
    end

endmodule

// File: tb/bankers_safety_and_request_tb.sv
// Self-checking testbench for the banker's safety and request engine.
// Depends on bsr_pkg and the bankers_safety_and_request RTL; a directed table runs
// first, then randomised phases over several register settings.
module bankers_safety_and_request_tb;
    import bsr_pkg::*;

    localparam int N_PROC        = 5;
    localparam int N_RES         = 3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int N_PHASES      = 7;

    // Command codes the engine leaves undefined
    localparam t_cmd CMD_SPARE_5 = 3'd5;
    localparam t_cmd CMD_SPARE_6 = 3'd6;
    localparam t_cmd CMD_SPARE_7 = 3'd7;
    // Register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef logic [4:0][2:0] t_order;
    typedef logic [2:0][7:0] t_amounts;

    typedef struct packed {
        t_status    status;
        logic [2:0] finished;
        t_order     order;
    } t_verdict;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] pidx;
        t_amounts   amt;
        logic       typed;
        t_verdict   want;
    } t_stim_row;

    localparam t_order ORDER_IN_INDEX = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

    // Register settings per random phase: written data, item count, amount scale, idle enable
    int         phase_pc_data [N_PHASES] = '{5, 0, 3, 255, 2, 4, 5};
    int         phase_rc_data [N_PHASES] = '{3, 1, 2, 254, 3, 128, 3};
    int         phase_items   [N_PHASES] = '{150, 80, 150, 120, 100, 100, 150};
    int         phase_scale   [N_PHASES] = '{15, 7, 255, 15, 255, 31, 15};
    logic       phase_idle    [N_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [CMD_W-1:0]       i_command;
    logic [PIDX_PORT_W-1:0] i_process_index;
    logic [7:0]             i_amount_0;
    logic [7:0]             i_amount_1;
    logic [7:0]             i_amount_2;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [STATUS_W-1:0]    o_status;
    logic [2:0]             o_finished_count;
    logic [2:0]             o_order_0;
    logic [2:0]             o_order_1;
    logic [2:0]             o_order_2;
    logic [2:0]             o_order_3;
    logic [2:0]             o_order_4;

    // Shadow copy of the engine's tables and registers
    logic [7:0] free_units  [N_RES];
    logic [7:0] max_claim   [N_PROC][N_RES];
    logic [7:0] held_units  [N_PROC][N_RES];
    int         still_needed[N_PROC][N_RES];
    int         proc_limit;
    int         res_limit;

    t_verdict   pending_verdicts[$];
    t_stim_row  directed_table[$];
    t_verdict   head_verdict;
    t_order     seen_order;
    logic       idle_on = 1'b1;
    int         ready_hold;
    int         items_sent = 0;
    int         results_seen = 0;
    int         mismatch_count = 0;
    int         settings_used = 1;
    int         cycle_count = 0;

    bankers_safety_and_request #(
        .PROCESSES  (N_PROC),
        .RESOURCES  (N_RES),
        .AMOUNT_BITS(8)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_process_index (i_process_index),
        .i_amount_0      (i_amount_0),
        .i_amount_1      (i_amount_1),
        .i_amount_2      (i_amount_2),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_finished_count(o_finished_count),
        .o_order_0       (o_order_0),
        .o_order_1       (o_order_1),
        .o_order_2       (o_order_2),
        .o_order_3       (o_order_3),
        .o_order_4       (o_order_4)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Safety scan: passes over unfinished processes in index order, admitting
    // any whose need fits in work; returns the number admitted
    function automatic int scan_safe_order(output t_order seq);
        int   work [N_RES];
        logic done [N_PROC];
        int   admitted;
        logic any_admitted;
        logic fits;
        seq = '0;
        admitted = 0;
        for (int r = 0; r < N_RES; r++) work[r] = int'(free_units[r]);
        for (int p = 0; p < N_PROC; p++) done[p] = 1'b0;
        for (int sweep = 0; sweep < proc_limit; sweep++) begin
            any_admitted = 1'b0;
            for (int p = 0; p < proc_limit; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < res_limit; r++)
                        if (still_needed[p][r] < 0 || still_needed[p][r] > work[r]) fits = 1'b0;
                    if (fits) begin
                        for (int r = 0; r < res_limit; r++) work[r] += int'(held_units[p][r]);
                        seq[admitted] = 3'(p);
                        admitted++;
                        done[p] = 1'b1;
                        any_admitted = 1'b1;
                    end
                end
            end
            if (!any_admitted) break;
        end
        return admitted;
    endfunction

    // Applies one command to the shadow tables and returns its result
    function automatic t_verdict predict_verdict(t_cmd c, logic [2:0] p, t_amounts amt);
        t_verdict v;
        t_order   seq;
        logic     over;
        logic     lacking;
        int       fin;
        int       pi;
        v = '0;
        pi = int'(p);
        if ((c == CMD_LOAD_MAX || c == CMD_LOAD_ALLOC || c == CMD_REQUEST) && pi >= proc_limit) begin
            v.status = ST_BAD_PROCESS;
        end else begin
            case (c)
                CMD_LOAD_AVAIL: begin
                    for (int r = 0; r < N_RES; r++) free_units[r] = amt[r];
                end
                CMD_LOAD_MAX, CMD_LOAD_ALLOC: begin
                    for (int r = 0; r < N_RES; r++) begin
                        if (c == CMD_LOAD_MAX) max_claim[pi][r] = amt[r];
                        else held_units[pi][r] = amt[r];
                        still_needed[pi][r] = int'(max_claim[pi][r]) - int'(held_units[pi][r]);
                    end
                end
                CMD_CHECK: begin
                    fin = scan_safe_order(seq);
                    v.order = seq;
                    v.finished = 3'(fin);
                    v.status = (fin == proc_limit) ? ST_SAFE : ST_UNSAFE;
                end
                CMD_REQUEST: begin
                    over = 1'b0;
                    lacking = 1'b0;
                    for (int r = 0; r < res_limit; r++) begin
                        if (still_needed[pi][r] < 0 || int'(amt[r]) > still_needed[pi][r])
                            over = 1'b1;
                        if (amt[r] > free_units[r]) lacking = 1'b1;
                    end
                    if (over) begin
                        v.status = ST_EXCEEDS;
                    end else if (lacking) begin
                        v.status = ST_MUST_WAIT;
                    end else begin
                        // tentative grant, undone if the scan cannot finish everyone
                        for (int r = 0; r < res_limit; r++) begin
                            free_units[r] = free_units[r] - amt[r];
                            held_units[pi][r] = held_units[pi][r] + amt[r];
                            still_needed[pi][r] -= int'(amt[r]);
                        end
                        fin = scan_safe_order(seq);
                        v.order = seq;
                        v.finished = 3'(fin);
                        if (fin == proc_limit) begin
                            v.status = ST_GRANTED;
                        end else begin
                            for (int r = 0; r < res_limit; r++) begin
                                free_units[r] = free_units[r] + amt[r];
                                held_units[pi][r] = held_units[pi][r] - amt[r];
                                still_needed[pi][r] += int'(amt[r]);
                            end
                            v.status = ST_DENIED;
                        end
                    end
                end
                default: v.status = ST_LOADED;
            endcase
        end
        return v;
    endfunction

    function automatic t_stim_row stim_row(t_cmd c, logic [2:0] p, logic [7:0] a0, logic [7:0] a1,
                                           logic [7:0] a2, logic typed = 1'b0,
                                           t_status st = ST_LOADED, logic [2:0] fin = 3'd0,
                                           t_order ord = '0);
        t_stim_row row_out;
        row_out.cmd = c;
        row_out.pidx = p;
        row_out.amt = {a2, a1, a0};
        row_out.typed = typed;
        row_out.want.status = st;
        row_out.want.finished = fin;
        row_out.want.order = ord;
        return row_out;
    endfunction

    // One command transaction; the expectation is queued once it is accepted
    task automatic send_item(input t_cmd c, input logic [2:0] p, input t_amounts amt,
                             input logic typed, input t_verdict want);
        t_verdict predicted;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_command = c;
        i_process_index = p;
        i_amount_0 = amt[0];
        i_amount_1 = amt[1];
        i_amount_2 = amt[2];
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_verdict(c, p, amt);
        pending_verdicts.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Hold the sender off until every result is back and the engine is quiet
    task automatic settle_engine();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        int v;
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        // counts are clamped into their legal ranges
        case (idx)
            CFG_PROCESS_COUNT: begin
                v = int'(data & 8'h07);
                proc_limit = (v < 1) ? 1 : ((v > N_PROC) ? N_PROC : v);
            end
            CFG_RESOURCE_COUNT: begin
                v = int'(data & 8'h03);
                res_limit = (v < 1) ? 1 : ((v > N_RES) ? N_RES : v);
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Fresh, mostly consistent tables: allocation within maximum on most rows
    task automatic load_scenario(input int scale);
        t_amounts amt;
        t_amounts ceiling;
        for (int r = 0; r < N_RES; r++) amt[r] = 8'($urandom_range(0, scale));
        send_item(CMD_LOAD_AVAIL, 3'd0, amt, 1'b0, '0);
        for (int p = 0; p < proc_limit; p++) begin
            for (int r = 0; r < N_RES; r++) ceiling[r] = 8'($urandom_range(0, scale));
            send_item(CMD_LOAD_MAX, 3'(p), ceiling, 1'b0, '0);
            for (int r = 0; r < N_RES; r++)
                amt[r] = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, int'(ceiling[r])));
            send_item(CMD_LOAD_ALLOC, 3'(p), amt, 1'b0, '0);
        end
    endtask

    // Random command: mostly requests within need, plus checks, reloads and noise
    task automatic send_random_item(input int scale);
        t_amounts amt;
        t_cmd     c;
        int       p;
        int       lim;
        int       mode;
        int       pick;
        pick = $urandom_range(0, 99);
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, proc_limit - 1);
        mode = $urandom_range(0, 9);
        for (int r = 0; r < N_RES; r++) amt[r] = 8'($urandom_range(0, scale));
        if (pick < 40) begin
            c = CMD_REQUEST;
            if (p < proc_limit && mode != 9)
                for (int r = 0; r < N_RES; r++) begin
                    lim = (still_needed[p][r] < 0) ? 0 : still_needed[p][r];
                    if (mode < 6 && lim > int'(free_units[r])) lim = int'(free_units[r]);
                    amt[r] = 8'($urandom_range(0, lim));
                end
        end else if (pick < 60) begin
            c = CMD_CHECK;
        end else if (pick < 80) begin
            c = (mode < 5) ? CMD_LOAD_MAX : CMD_LOAD_ALLOC;
            if (p < proc_limit && mode != 9)
                for (int r = 0; r < N_RES; r++) begin
                    if (c == CMD_LOAD_MAX) begin
                        lim = int'(held_units[p][r]) + $urandom_range(0, scale);
                        amt[r] = (lim > 255) ? 8'd255 : 8'(lim);
                    end else begin
                        amt[r] = 8'($urandom_range(0, int'(max_claim[p][r])));
                    end
                end
        end else if (pick < 88) begin
            c = CMD_LOAD_AVAIL;
        end else begin
            c = t_cmd'($urandom_range(0, 7));
            p = $urandom_range(0, 7);
            for (int r = 0; r < N_RES; r++) amt[r] = 8'($urandom_range(0, 255));
        end
        send_item(c, 3'(p), amt, 1'b0, '0);
    endtask

    // Result side back-pressure in short bursts
    initial begin
        i_out_ready = 1'b0;
        ready_hold = 0;
        forever begin
            @(negedge i_clk);
            if (idle_on && ready_hold == 0 && $urandom_range(0, 5) == 0)
                ready_hold = $urandom_range(1, 5);
            if (ready_hold > 0) begin
                i_out_ready = 1'b0;
                ready_hold--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Result checker: oldest expectation first, field by field
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                $error("result transaction with nothing expected: status %0d", o_status);
            end else begin
                head_verdict = pending_verdicts.pop_front();
                seen_order = {o_order_4, o_order_3, o_order_2, o_order_1, o_order_0};
                if (o_status !== head_verdict.status) begin
                    mismatch_count++;
                    $error("status: expected %0d, got %0d", head_verdict.status, o_status);
                end
                if (o_finished_count !== head_verdict.finished) begin
                    mismatch_count++;
                    $error("finished_count: expected %0d, got %0d", head_verdict.finished,
                           o_finished_count);
                end
                for (int i = 0; i < SHOWN_ORDERS; i++)
                    if (seen_order[i] !== head_verdict.order[i]) begin
                        mismatch_count++;
                        $error("order_%0d: expected %0d, got %0d", i, head_verdict.order[i],
                               seen_order[i]);
                    end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int phase_start;
        int step;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PROCESS_COUNT;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_LOAD_AVAIL;
        i_process_index = '0;
        i_amount_0 = '0;
        i_amount_1 = '0;
        i_amount_2 = '0;

        // shadow state after reset
        proc_limit = N_PROC;
        res_limit = N_RES;
        for (int r = 0; r < N_RES; r++) free_units[r] = '0;
        for (int p = 0; p < N_PROC; p++)
            for (int r = 0; r < N_RES; r++) begin
                max_claim[p][r] = '0;
                held_units[p][r] = '0;
                still_needed[p][r] = 0;
            end

        // Directed table: textbook five-process example, then the corner cases
        directed_table.push_back(stim_row(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0, 1'b1, ST_SAFE, 3'd5,
                                          ORDER_IN_INDEX));
        directed_table.push_back(stim_row(CMD_LOAD_AVAIL, 3'd0, 8'd3, 8'd3, 8'd2, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_MAX, 3'd0, 8'd7, 8'd5, 8'd3, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_MAX, 3'd1, 8'd3, 8'd2, 8'd2, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_MAX, 3'd2, 8'd9, 8'd0, 8'd2, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_MAX, 3'd3, 8'd2, 8'd2, 8'd2, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_MAX, 3'd4, 8'd4, 8'd3, 8'd3, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_ALLOC, 3'd0, 8'd0, 8'd1, 8'd0, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_ALLOC, 3'd1, 8'd2, 8'd0, 8'd0, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_ALLOC, 3'd2, 8'd3, 8'd0, 8'd2, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_ALLOC, 3'd3, 8'd2, 8'd1, 8'd1, 1'b1));
        directed_table.push_back(stim_row(CMD_LOAD_ALLOC, 3'd4, 8'd0, 8'd0, 8'd2, 1'b1));
        directed_table.push_back(stim_row(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0));
        directed_table.push_back(stim_row(CMD_REQUEST, 3'd1, 8'd1, 8'd0, 8'd2));
        directed_table.push_back(stim_row(CMD_REQUEST, 3'd4, 8'd3, 8'd3, 8'd0));
        directed_table.push_back(stim_row(CMD_REQUEST, 3'd0, 8'd0, 8'd2, 8'd0));
        directed_table.push_back(stim_row(CMD_REQUEST, 3'd3, 8'd255, 8'd0, 8'd0, 1'b1,
                                          ST_EXCEEDS));
        directed_table.push_back(stim_row(CMD_LOAD_MAX, 3'd5, 8'd255, 8'd255, 8'd255, 1'b1,
                                          ST_BAD_PROCESS));
        directed_table.push_back(stim_row(CMD_REQUEST, 3'd7, 8'd0, 8'd0, 8'd0, 1'b1,
                                          ST_BAD_PROCESS));
        directed_table.push_back(stim_row(CMD_SPARE_5, 3'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        directed_table.push_back(stim_row(CMD_SPARE_6, 3'd7, 8'd255, 8'd255, 8'd255, 1'b1));
        directed_table.push_back(stim_row(CMD_SPARE_7, 3'd3, 8'd170, 8'd85, 8'd255, 1'b1));
        // allocation above maximum: negative need
        directed_table.push_back(stim_row(CMD_LOAD_ALLOC, 3'd2, 8'd255, 8'd255, 8'd255, 1'b1));
        directed_table.push_back(stim_row(CMD_CHECK, 3'd0, 8'd0, 8'd0, 8'd0));
        directed_table.push_back(stim_row(CMD_REQUEST, 3'd2, 8'd0, 8'd0, 8'd0, 1'b1,
                                          ST_EXCEEDS));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_table[i])
            send_item(directed_table[i].cmd, directed_table[i].pidx, directed_table[i].amt,
                      directed_table[i].typed, directed_table[i].want);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle_engine();
            write_register(CFG_PROCESS_COUNT, 8'(phase_pc_data[ph]));
            write_register(CFG_RESOURCE_COUNT, 8'(phase_rc_data[ph]));
            if (ph == 3) write_register(CFG_SPARE_INDEX, 8'($urandom_range(0, 255)));
            settings_used++;
            idle_on = phase_idle[ph];
            phase_start = items_sent;
            step = 0;
            while (items_sent - phase_start < phase_items[ph]) begin
                if (step % 30 == 0) load_scenario(phase_scale[ph]);
                // sender waits for the engine to drain mid-phase
                if (step == phase_items[ph] / 2) settle_engine();
                // last stretch of the run without idling
                if (ph == N_PHASES - 1 && items_sent - phase_start >= phase_items[ph] - 100)
                    idle_on = 1'b0;
                send_random_item(phase_scale[ph]);
                step++;
            end
        end

        settle_engine();
        $display("Sent %0d commands and compared %0d results over %0d register settings,",
                 items_sent, results_seen, settings_used);
        $display("process counts 1 to 5, resource counts 1 to 3, stalls on both sides.");
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
